/* src/rtpl_pkg.sv */
// Shared constants and types for the resonant three-pole lowpass filter.
package rtpl_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_STATE_WIDTH  = 32;

  // Coefficient registers and their fractional points
  localparam int COEF_WIDTH = 16;
  localparam int COEF_FRAC  = 16;
  localparam int GAIN_FRAC  = 12;
  localparam logic [COEF_WIDTH-1:0] CUTOFF_RESET = 16'd65470;

  // Multiplier digit size and number of digits in a coefficient
  localparam int DIGIT_W = 4;
  localparam int NUM_DIGITS = COEF_WIDTH / DIGIT_W;

  // Operand headroom above the stage width for the feedback and drive terms
  localparam int OPER_EXTRA = 7;

  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CUTOFF = 1'b0,
    REG_GAIN   = 1'b1
  } cfg_reg_t;

endpackage

/* src/rtpl_mul.sv */
// Digit-serial signed-by-unsigned multiplier, one coefficient digit per cycle.
module rtpl_mul #(
  parameter int A_WIDTH = rtpl_pkg::DEF_STATE_WIDTH + rtpl_pkg::OPER_EXTRA
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic signed [A_WIDTH-1:0]                 a,
  input  logic        [rtpl_pkg::COEF_WIDTH-1:0]    b,
  output logic                                      done,
  output logic signed [A_WIDTH+rtpl_pkg::COEF_WIDTH-1:0] product
);
  import rtpl_pkg::*;

  localparam int PW    = A_WIDTH + COEF_WIDTH;
  localparam int CNT_W = $clog2(NUM_DIGITS + 1);

  logic signed [A_WIDTH-1:0]   a_r;
  logic        [COEF_WIDTH-1:0] b_r;
  logic signed [PW-1:0]        acc;
  logic        [CNT_W-1:0]     cnt;
  logic                        done_r;

  logic        [DIGIT_W-1:0]        digit;
  logic signed [A_WIDTH+DIGIT_W:0]  pp;
  logic signed [PW-1:0]             acc_next;

  // Most significant digit first: shift the partial sum up, add the next row
  assign digit    = b_r[COEF_WIDTH-1 -: DIGIT_W];
  assign pp       = a_r * $signed({1'b0, digit});
  assign acc_next = (acc <<< DIGIT_W) + PW'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_DIGITS);
      end else if (cnt != '0) begin
        cnt    <= cnt - CNT_W'(1);
        done_r <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (cnt != '0) begin
      b_r <= b_r << DIGIT_W;
      acc <= acc_next;
    end
  end

  assign done    = done_r;
  assign product = acc;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> cnt == '0)
    else $error("multiplier started while busy");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
      start |=> cnt == CNT_W'(NUM_DIGITS))
    else $error("multiplier did not load its digit count");

endmodule

/* src/resonant_three_pole_lowpass.sv */
// Top level of the resonant three-pole lowpass filter.
// Each item carries one signed sample that runs through three cascaded one-pole
// stages, the first with resonance feedback; the result is the third stage
// saturated back to sample format. All four products of an item (feedback,
// then one per stage) go one after another through a single multiplier that
// takes one 4-bit coefficient digit per cycle. A sample passes the accepting
// cycle, then per product an operand state, the digit steps and an update
// step, then the load of the output register; the next sample is accepted
// only after that load. A clear item zeroes the stages and returns 0.
// in_ready is high only between items; a finished result waits in the
// output register and does not block acceptance of the next item, but the next
// result holds in the load cycle until the waiting one has been taken.
module resonant_three_pole_lowpass #(
  parameter int SAMPLE_WIDTH = rtpl_pkg::DEF_SAMPLE_WIDTH,
  parameter int STATE_WIDTH  = rtpl_pkg::DEF_STATE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rtpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rtpl_pkg::COEF_WIDTH-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  logic                                clear,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import rtpl_pkg::*;

  localparam int AW  = STATE_WIDTH + OPER_EXTRA;
  localparam int PW  = AW + COEF_WIDTH;
  localparam int SW  = STATE_WIDTH + 8;
  localparam int FBW = STATE_WIDTH + 5;
  localparam int SH  = STATE_WIDTH - SAMPLE_WIDTH - 7;
  localparam int YW  = (SH >= 0) ? STATE_WIDTH : STATE_WIDTH - SH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LAUNCH = 4'b0010,
    S_MUL    = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    STEP_FB    = 2'd0,
    STEP_ONE   = 2'd1,
    STEP_TWO   = 2'd2,
    STEP_THREE = 2'd3
  } step_t;

  state_t state;
  step_t  step;

  logic [COEF_WIDTH-1:0] cutoff;
  logic [COEF_WIDTH-1:0] gain;

  logic signed [STATE_WIDTH-1:0] s1, s2, s3;
  logic signed [STATE_WIDTH-1:0] x_r;
  logic signed [FBW-1:0]         fbr;

  logic signed [STATE_WIDTH-1:0] x_in;
  logic signed [YW-1:0]          y_full;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic [YW-SAMPLE_WIDTH:0]      y_top;

  logic                  mul_start;
  logic signed [AW-1:0]  mul_a;
  logic [COEF_WIDTH-1:0] mul_b;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;

  logic signed [STATE_WIDTH-1:0] stage_cur;
  logic signed [STATE_WIDTH-1:0] stage_upd;
  logic                          accept;
  logic                          out_load;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [SW-1:0] v);
    logic [SW-STATE_WIDTH:0] top_bits;
    top_bits = v[SW-1:STATE_WIDTH-1];
    if (&top_bits || ~|top_bits) begin
      sat_state = v[STATE_WIDTH-1:0];
    end else if (v[SW-1]) begin
      sat_state = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      sat_state = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Sample format to stage format and back; narrowing shifts floor
  generate
    if (SH >= 0) begin : g_down
      assign x_in   = STATE_WIDTH'(sample_in) <<< SH;
      assign y_full = s3 >>> SH;
    end else begin : g_up
      assign x_in   = STATE_WIDTH'(sample_in >>> (-SH));
      assign y_full = YW'(s3) <<< (-SH);
    end
  endgenerate

  assign y_top = y_full[YW-1:SAMPLE_WIDTH-1];
  always_comb begin
    if (&y_top || ~|y_top) begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
    end else if (y_full[YW-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mul_start = (state == S_LAUNCH);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // Operand for the product of the current step, from settled registers
  always_comb begin
    case (step)
      STEP_FB: begin
        mul_a = AW'(s1) - AW'(s2);
        mul_b = gain;
      end
      STEP_ONE: begin
        mul_a = AW'(x_r) - AW'(s1) + AW'(fbr);
        mul_b = cutoff;
      end
      STEP_TWO: begin
        mul_a = AW'(s1) - AW'(s2);
        mul_b = cutoff;
      end
      STEP_THREE: begin
        mul_a = AW'(s2) - AW'(s3);
        mul_b = cutoff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (step)
      STEP_TWO:   stage_cur = s2;
      STEP_THREE: stage_cur = s3;
      default:    stage_cur = s1;
    endcase
  end

  assign stage_upd = sat_state(SW'(stage_cur) + SW'(mul_p >>> COEF_FRAC));

  rtpl_mul #(
    .A_WIDTH (AW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
      gain   <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUTOFF: cutoff <= cfg_data;
        REG_GAIN:   gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_FB;
      s1        <= '0;
      s2        <= '0;
      s3        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            step <= STEP_FB;
            if (clear) begin
              s1    <= '0;
              s2    <= '0;
              s3    <= '0;
              state <= S_OUT;
            end else begin
              state <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            case (step)
              STEP_ONE:   s1 <= stage_upd;
              STEP_TWO:   s2 <= stage_upd;
              STEP_THREE: s3 <= stage_upd;
              default: ;
            endcase
            if (step == STEP_THREE) begin
              state <= S_OUT;
            end else begin
              step  <= step_t'(step + 2'd1);
              state <= S_LAUNCH;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_in;
    end
    if (state == S_MUL && mul_done && step == STEP_FB) begin
      fbr <= FBW'(mul_p >>> GAIN_FRAC);
    end
    if (out_load) begin
      sample_out <= y_sat;
    end
  end

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
      accept && clear |=> s1 == '0 && s2 == '0 && s3 == '0)
    else $error("clear item did not zero the stages");
  a_launch_quiet: assert property (@(posedge clk) disable iff (rst) mul_start |-> !mul_done)
    else $error("multiply launched while another finished");
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
      state == S_OUT && out_valid && !out_ready |=> state == S_OUT)
    else $error("result dropped while output register was full");
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
      mul_done |-> state == S_MUL)
    else $error("multiply finished outside the multiply state");

endmodule
